FILE: rtl/url_percent_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// URL percent encoder assertion macros
// Shared concurrent assertion forms; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_ENCODER_TOP_MACROS_SVH
`define URL_PERCENT_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define UPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define UPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/upe_pkg.sv
// ----------------------------------------------------------------------------
// URL percent encoder package
// Character constants, command types and character lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package upe_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FORM_MODE = 3'd0;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_PCT   = 7'h25;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_D     = 7'h44;
    localparam logic [6:0] CH_A     = 7'h41;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CHAR,
        KIND_ESC,
        KIND_CRLF
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    function automatic logic is_unreserved(input logic [7:0] b);
        logic r;
        r = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
            ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2D) || (b == 8'h2E) ||
            (b == 8'h5F) || (b == 8'h7E);
        return r;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] r;
        if (n < 4'd10) begin
            r = 7'h30 + {3'b000, n};
        end else begin
            r = 7'h37 + {3'b000, n};
        end
        return r;
    endfunction

    function automatic logic [2:0] cmd_last_step(input t_kind kind);
        logic [2:0] r;
        case (kind)
            KIND_ESC:  r = 3'd2;
            KIND_CRLF: r = 3'd5;
            default:   r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] cmd_char(input t_cmd cmd, input logic [2:0] step);
        logic [6:0] r;
        r = CH_PCT;
        case (cmd.kind)
            KIND_CHAR: begin
                r = cmd.data[6:0];
            end
            KIND_ESC: begin
                case (step)
                    3'd0:    r = CH_PCT;
                    3'd1:    r = hex_char(cmd.data[7:4]);
                    default: r = hex_char(cmd.data[3:0]);
                endcase
            end
            KIND_CRLF: begin
                case (step)
                    3'd1, 3'd4: r = CH_ZERO;
                    3'd2:       r = CH_D;
                    3'd5:       r = CH_A;
                    default:    r = CH_PCT;
                endcase
            end
            default: begin
                r = CH_PCT;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/upe_in_if.sv
// ----------------------------------------------------------------------------
// URL percent encoder input channel
// Valid/ready channel carrying one raw byte and its end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface upe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/upe_out_if.sv
// ----------------------------------------------------------------------------
// URL percent encoder output channel
// Valid/ready channel carrying one encoded character and its run-end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface upe_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink (input valid, input out_char, input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/url_percent_encoder_top.sv
// ----------------------------------------------------------------------------
// URL percent encoder top level
// Byte stream in, percent-encoded character stream out.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction carries one byte of a string and an end-of-string
// mark. Each output transaction carries one encoded character; run_last is
// set on the final character produced for that input byte.
// An unreserved byte, or a space in form mode, gives one character. Any other
// byte gives three. In form mode CR or LF gives six, and an LF right after a
// CR of the same string gives none.
// A taken byte passes through the command queue, then the output register.
// Characters leave at one per cycle while the output is ready, from the
// single character generator in the back end.
// A command queue lets the input keep taking bytes while the output is
// stalled; when it fills, input ready falls until characters drain.
// Reset empties the queue and the output register, clears the pending CR and
// sets form_mode to zero. form_mode is at byte address zero of the APB port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_percent_encoder_top_macros.svh"

module url_percent_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    upe_in_if.sink                               i_in_ch,
    upe_out_if.source                            o_out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [upe_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [upe_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [upe_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import upe_pkg::*;

    logic r_form_mode;
    logic cfg_write;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic cr_pending;
    logic cr_taken;
    logic pct_out;
    t_cmd push_cmd;
    t_cmd q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_FORM_MODE);
    assign prdata    = (paddr == ADDR_FORM_MODE) ? {{(CFG_DATA_W-1){1'b0}}, r_form_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_form_mode <= 1'b0;
        end else if (cfg_write) begin
            r_form_mode <= pwdata[0];
        end
    end

    upe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_ch.valid),
        .i_byte       (i_in_ch.in_byte),
        .i_last       (i_in_ch.in_last),
        .i_form_mode  (r_form_mode),
        .i_q_full     (q_full),
        .o_ready      (i_in_ch.ready),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_cr_pending (cr_pending)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    upe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_out_char  (o_out_ch.out_char),
        .o_run_last  (o_out_ch.run_last)
    );

    assign cr_taken = i_in_ch.valid && i_in_ch.ready && r_form_mode &&
                      (i_in_ch.in_byte == CH_CR) && !i_in_ch.in_last;
    assign pct_out  = o_out_ch.valid && (o_out_ch.out_char == CH_PCT);

    `UPE_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, push, !q_full)
    `UPE_ASSERT_NEXT(a_cr_sets_pending, i_clk, i_rst_n, cr_taken, cr_pending)
    `UPE_ASSERT_SAME(a_pct_not_last, i_clk, i_rst_n, pct_out, !o_out_ch.run_last)

endmodule

`default_nettype wire

FILE: rtl/upe_front.sv
// ----------------------------------------------------------------------------
// URL percent encoder front end
// Accepts input bytes, classifies them and tracks a pending carriage return.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_last,
    input  wire logic         i_form_mode,
    input  wire logic         i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output upe_pkg::t_cmd     o_cmd,
    output logic              o_cr_pending
);
    import upe_pkg::*;

    logic r_cr_pending;
    logic n_cr_pending;
    logic accept;
    logic is_nl;
    t_cmd cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_nl   = (i_byte == CH_LF) || (i_byte == CH_CR);

    always_comb begin
        cmd.data = i_byte;
        if (i_form_mode && is_nl) begin
            if ((i_byte == CH_LF) && r_cr_pending) begin
                cmd.kind = KIND_NONE;
            end else begin
                cmd.kind = KIND_CRLF;
            end
        end else if (i_form_mode && (i_byte == CH_SPACE)) begin
            cmd.kind = KIND_CHAR;
            cmd.data = {1'b0, CH_PLUS};
        end else if (is_unreserved(i_byte)) begin
            cmd.kind = KIND_CHAR;
        end else begin
            cmd.kind = KIND_ESC;
        end
    end

    always_comb begin
        n_cr_pending = r_cr_pending;
        if (accept) begin
            n_cr_pending = i_form_mode && (i_byte == CH_CR) && !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pending <= 1'b0;
        end else begin
            r_cr_pending <= n_cr_pending;
        end
    end

    assign o_push       = accept && (cmd.kind != KIND_NONE);
    assign o_cmd        = cmd;
    assign o_cr_pending = r_cr_pending;

endmodule

`default_nettype wire

FILE: rtl/upe_queue.sv
// ----------------------------------------------------------------------------
// URL percent encoder command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire upe_pkg::t_cmd  i_push_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output upe_pkg::t_cmd       o_head
);
    import upe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/upe_back.sv
// ----------------------------------------------------------------------------
// URL percent encoder back end
// Expands queued commands into output characters, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module upe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire upe_pkg::t_cmd  i_q_head,
    output logic                o_pop,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [6:0]          o_out_char,
    output logic                o_run_last
);
    import upe_pkg::*;

    logic [2:0] r_step;
    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_run_last;
    logic [2:0] n_step;
    logic       n_out_valid;
    logic       load;
    logic       step_last;

    assign load      = i_q_valid && (!r_out_valid || i_out_ready);
    assign step_last = (r_step == cmd_last_step(i_q_head.kind));
    assign o_pop     = load && step_last;

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
            n_step      = step_last ? 3'd0 : r_step + 3'd1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= cmd_char(i_q_head, r_step);
            r_run_last <= step_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_run_last  = r_run_last;

endmodule

`default_nettype wire
